>>> sv/be3d_pkg.sv
// Shared types and constants for the 3D binary erosion unit.
// No dependencies; used by binary_erosion_3d_6n_unit.
`default_nettype none

package be3d_pkg;

   // Size registers and their write port
   localparam int SIZE_W       = 7;
   localparam int CSR_INDEX_W  = 2;
   localparam int RESET_SIZE   = 64;

   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_Y = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_Z = 2'd2;

   // Stream data width (one payload bit padded to a byte)
   localparam int TDATA_W = 8;

   // Result queue
   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_PTR_W      = 2;
   localparam int RSP_CNT_W      = 3;

   // One store entry: the plane before last and the last plane at one (y,z)
   typedef struct packed {
      logic older;
      logic newer;
   } pair_type;

   // Per-word control carried from acceptance into the memory read cycle
   typedef struct packed {
      logic is_out;
      logic x_first;
      logic x_last;
      logic y_first;
      logic y_last;
      logic z_first;
      logic z_last;
      logic vin;
   } step_type;

   // Which reads collide with the write-back of the word just ahead
   typedef struct packed {
      logic ctr;
      logic yp;
      logic ym;
      logic zp;
   } fwd_type;

   // One result word
   typedef struct packed {
      logic last;
      logic voxel;
   } result_type;

endpackage

`default_nettype wire

>>> sv/binary_erosion_3d_6n_unit.sv
// Streaming 3D binary erosion, 6-connected, over a raster-ordered voxel stream.
// Depends on be3d_pkg (types, register indexes, queue sizing).
//
//  channel | ports                              | payload
//  --------+------------------------------------+------------------------------------
//  req     | req_tvalid/req_tready              | tdata[0] voxel_in, tuser flush
//  rsp     | rsp_tvalid/rsp_tready              | tdata[0] voxel_out, tlast last_voxel
//  csr     | csr_wen, csr_index, csr_wdata      | size_x (0), size_y (1), size_z (2)
//
// One voxel word per cycle sustained. Each word reads two dual-read-port plane
// memories at its acceptance edge and writes back in the next cycle; a collision
// with the word just ahead is forwarded. A result enters the output queue from the
// read stage, the cycle after acceptance. req_tready drops only when the 4-entry
// result queue plus the word in flight would overflow. Reset needs no clearing pass:
// stale store entries are never selected. No result comes out during the first plane.
`default_nettype none

module binary_erosion_3d_6n_unit #(
   parameter int MAX_X = 64,
   parameter int MAX_Y = 64,
   parameter int MAX_Z = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [be3d_pkg::TDATA_W-1:0]        req_tdata,  // [0] voxel_in, rest zero
   input  wire logic                                req_tuser,  // [0] flush
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [be3d_pkg::TDATA_W-1:0]             rsp_tdata,  // [0] voxel_out, rest zero
   output logic                                     rsp_tlast,  // last_voxel
   input  wire logic                                csr_wen,
   input  wire logic [be3d_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [be3d_pkg::SIZE_W-1:0]         csr_wdata
);

   localparam int XW    = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int YW    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int ZW    = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
   localparam int DEPTH = MAX_Y * MAX_Z;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [AW-1:0] ROW_STEP = AW'(MAX_Z);

   localparam logic [be3d_pkg::SIZE_W-1:0] RST_X = (MAX_X < be3d_pkg::RESET_SIZE) ?
      be3d_pkg::SIZE_W'(MAX_X) : be3d_pkg::SIZE_W'(be3d_pkg::RESET_SIZE);
   localparam logic [be3d_pkg::SIZE_W-1:0] RST_Y = (MAX_Y < be3d_pkg::RESET_SIZE) ?
      be3d_pkg::SIZE_W'(MAX_Y) : be3d_pkg::SIZE_W'(be3d_pkg::RESET_SIZE);
   localparam logic [be3d_pkg::SIZE_W-1:0] RST_Z = (MAX_Z < be3d_pkg::RESET_SIZE) ?
      be3d_pkg::SIZE_W'(MAX_Z) : be3d_pkg::SIZE_W'(be3d_pkg::RESET_SIZE);

   // zero reads as one, above the maximum reads as the maximum
   function automatic logic [be3d_pkg::SIZE_W-1:0] clamp_size(
      input logic [be3d_pkg::SIZE_W-1:0] v,
      input int                          maxv
   );
      if (v == '0) begin
         return be3d_pkg::SIZE_W'(1);
      end else if (32'(v) > maxv) begin
         return be3d_pkg::SIZE_W'(maxv);
      end
      return v;
   endfunction

   // ------------------------------------------------------------------
   // Declarations
   // ------------------------------------------------------------------
   logic [be3d_pkg::SIZE_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [be3d_pkg::SIZE_W-1:0] size_x_in, size_y_in, size_z_in;
   logic                        cfg_hit;

   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [ZW-1:0] z_ff, z_in;
   logic [AW-1:0] row_base_ff, row_base_in;
   logic          filled_ff, filled_in;

   logic accept;
   logic x_first, x_last, y_first, y_last, z_first, z_last;
   logic vin, end_vol;

   logic [AW-1:0] addr_ctr, addr_yp, addr_ym, addr_zp;

   be3d_pkg::pair_type mem_a [2**AW];
   be3d_pkg::pair_type mem_b [2**AW];
   be3d_pkg::pair_type rd_ctr_ff, rd_yp_ff, rd_ym_ff, rd_zp_ff;

   logic               rd_valid_ff;
   be3d_pkg::step_type rd_step_ff, step_in;
   logic [AW-1:0]      rd_addr_ff;
   be3d_pkg::fwd_type  fwd_ff, fwd_in;
   be3d_pkg::pair_type fwd_data_ff;

   be3d_pkg::pair_type ctr_pair, yp_pair, ym_pair, zp_pair;
   be3d_pkg::pair_type wr_data;
   logic               center, prev_center_ff, prev_center_in;
   logic               wr_en, push, pop;
   be3d_pkg::result_type result;

   be3d_pkg::result_type                 fifo_ff [be3d_pkg::RSP_FIFO_DEPTH];
   logic [be3d_pkg::RSP_PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [be3d_pkg::RSP_CNT_W-1:0]       cnt_ff, cnt_in;

   // ------------------------------------------------------------------
   // Size registers
   // ------------------------------------------------------------------
   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      cfg_hit   = 1'b0;
      if (csr_wen) begin
         unique case (csr_index)
            be3d_pkg::REG_SIZE_X: begin
               size_x_in = clamp_size(csr_wdata, MAX_X);
               cfg_hit   = 1'b1;
            end
            be3d_pkg::REG_SIZE_Y: begin
               size_y_in = clamp_size(csr_wdata, MAX_Y);
               cfg_hit   = 1'b1;
            end
            be3d_pkg::REG_SIZE_Z: begin
               size_z_in = clamp_size(csr_wdata, MAX_Z);
               cfg_hit   = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= RST_X;
         size_y_ff <= RST_Y;
         size_z_ff <= RST_Z;
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
         size_z_ff <= size_z_in;
      end
   end

   // ------------------------------------------------------------------
   // Position of the word at the input
   // ------------------------------------------------------------------
   assign accept  = req_tvalid && req_tready;
   assign x_first = (x_ff == '0);
   assign y_first = (y_ff == '0);
   assign z_first = (z_ff == '0);
   assign x_last  = ((32'(x_ff) + 32'd1) == 32'(size_x_ff));
   assign y_last  = ((32'(y_ff) + 32'd1) == 32'(size_y_ff));
   assign z_last  = ((32'(z_ff) + 32'd1) == 32'(size_z_ff));
   assign vin     = req_tdata[0] & ~req_tuser;
   assign end_vol = filled_ff & x_last & y_last & z_last;

   always_comb begin
      x_in        = x_ff;
      y_in        = y_ff;
      z_in        = z_ff;
      row_base_in = row_base_ff;
      filled_in   = filled_ff;
      if (cfg_hit || (accept && end_vol)) begin
         x_in        = '0;
         y_in        = '0;
         z_in        = '0;
         row_base_in = '0;
         filled_in   = 1'b0;
      end else if (accept) begin
         if (z_last) begin
            z_in = '0;
            if (y_last) begin
               y_in        = '0;
               row_base_in = '0;
               // first pass over a plane only primes the stores
               if (filled_ff) begin
                  x_in = x_ff + 1'b1;
               end else begin
                  filled_in = 1'b1;
               end
            end else begin
               y_in        = y_ff + 1'b1;
               row_base_in = row_base_ff + ROW_STEP;
            end
         end else begin
            z_in = z_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff        <= '0;
         y_ff        <= '0;
         z_ff        <= '0;
         row_base_ff <= '0;
         filled_ff   <= 1'b0;
      end else begin
         x_ff        <= x_in;
         y_ff        <= y_in;
         z_ff        <= z_in;
         row_base_ff <= row_base_in;
         filled_ff   <= filled_in;
      end
   end

   // ------------------------------------------------------------------
   // Plane memories: two copies with the same writes, two reads each
   // ------------------------------------------------------------------
   assign addr_ctr = row_base_ff + AW'(z_ff);
   assign addr_yp  = addr_ctr + ROW_STEP;
   assign addr_ym  = addr_ctr - ROW_STEP;
   assign addr_zp  = addr_ctr + AW'(1);

   always_ff @(posedge clock) begin
      rd_ctr_ff <= mem_a[addr_ctr];
      rd_yp_ff  <= mem_a[addr_yp];
      if (wr_en) begin
         mem_a[rd_addr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_ym_ff <= mem_b[addr_ym];
      rd_zp_ff <= mem_b[addr_zp];
      if (wr_en) begin
         mem_b[rd_addr_ff] <= wr_data;
      end
   end

   // ------------------------------------------------------------------
   // Read stage capture, with collision check against the write-back
   // ------------------------------------------------------------------
   always_comb begin
      step_in.is_out  = filled_ff;
      step_in.x_first = x_first;
      step_in.x_last  = x_last;
      step_in.y_first = y_first;
      step_in.y_last  = y_last;
      step_in.z_first = z_first;
      step_in.z_last  = z_last;
      step_in.vin     = vin;
      fwd_in.ctr      = rd_valid_ff && (addr_ctr == rd_addr_ff);
      fwd_in.yp       = rd_valid_ff && (addr_yp == rd_addr_ff);
      fwd_in.ym       = rd_valid_ff && (addr_ym == rd_addr_ff);
      fwd_in.zp       = rd_valid_ff && (addr_zp == rd_addr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff    <= 1'b0;
         prev_center_ff <= 1'b0;
      end else begin
         rd_valid_ff    <= accept;
         prev_center_ff <= prev_center_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_step_ff  <= step_in;
      rd_addr_ff  <= addr_ctr;
      fwd_ff      <= fwd_in;
      fwd_data_ff <= wr_data;
   end

   // ------------------------------------------------------------------
   // Erosion of the word in the read stage and write-back
   // ------------------------------------------------------------------
   always_comb begin
      ctr_pair = fwd_ff.ctr ? fwd_data_ff : rd_ctr_ff;
      yp_pair  = fwd_ff.yp  ? fwd_data_ff : rd_yp_ff;
      ym_pair  = fwd_ff.ym  ? fwd_data_ff : rd_ym_ff;
      zp_pair  = fwd_ff.zp  ? fwd_data_ff : rd_zp_ff;
      center   = ctr_pair.newer;

      // out-of-volume neighbors count as set
      result.voxel = center
                   & (rd_step_ff.x_first | ctr_pair.older)
                   & (rd_step_ff.x_last  | rd_step_ff.vin)
                   & (rd_step_ff.y_first | ym_pair.older)
                   & (rd_step_ff.y_last  | yp_pair.newer)
                   & (rd_step_ff.z_first | prev_center_ff)
                   & (rd_step_ff.z_last  | zp_pair.newer);
      result.last  = rd_step_ff.x_last & rd_step_ff.y_last & rd_step_ff.z_last;

      wr_en          = rd_valid_ff;
      wr_data.older  = center;
      wr_data.newer  = rd_step_ff.vin;
      push           = rd_valid_ff && rd_step_ff.is_out;
      prev_center_in = rd_valid_ff ? center : prev_center_ff;
   end

   // ------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = {{(be3d_pkg::TDATA_W-1){1'b0}}, fifo_ff[rd_ptr_ff].voxel};
   assign rsp_tlast  = fifo_ff[rd_ptr_ff].last;
   assign req_tready = (cnt_ff + be3d_pkg::RSP_CNT_W'(rd_valid_ff))
                       < be3d_pkg::RSP_CNT_W'(be3d_pkg::RSP_FIFO_DEPTH);

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= result;
      end
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // result queue is never written while full, unless an entry is popped in that cycle
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (cnt_ff < be3d_pkg::RSP_CNT_W'(be3d_pkg::RSP_FIFO_DEPTH)))
      else $error("result queue overflow");

   // the last word of a volume returns the position to the origin
   a_volume_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && end_vol && !cfg_hit) |=>
         (x_ff == '0 && y_ff == '0 && z_ff == '0 && !filled_ff))
      else $error("position did not wrap at end of volume");

   // priming flag clears only on a size write or at the end of a volume
   a_fill_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(filled_ff) |-> $past(cfg_hit || (accept && end_vol)))
      else $error("priming flag cleared unexpectedly");

endmodule

`default_nettype wire
